FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they vanish when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define DMFE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// An antecedent that must be followed by a consequent in the next cycle.
`define DMFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DMFE_ASSERT(lbl, clk, rst, prop)
`define DMFE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: sv/dmfe_pkg.sv
// ----------------------------------------------------------------------------
// dmfe_pkg
// Shared widths, opcodes and structures of the feature expander.
// ----------------------------------------------------------------------------
package dmfe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FEAT_W   = 32;
  localparam int INDEX_W  = 6;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // One output word.
  typedef struct packed {
    logic signed [FEAT_W-1:0] value;
    logic [INDEX_W-1:0]       index;
    logic                     is_mono;
    logic                     last;
  } feat_t;

endpackage

FILE: sv/dmfe_front.sv
// ----------------------------------------------------------------------------
// dmfe_front
// Accepts input words, assembles sample vectors and issues commands.
// ----------------------------------------------------------------------------
module dmfe_front import dmfe_pkg::*; #(
  parameter int NUM_ELEMS = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            opcode,
  input  logic signed [SAMPLE_W-1:0]      element_value,
  input  logic                            end_of_sample,
  input  qstat_t                          q_stat,
  output logic                            q_wr,
  output logic [NUM_ELEMS*SAMPLE_W:0]     q_word
);

  localparam int CNT_W = $clog2(NUM_ELEMS + 1);

  logic [CNT_W-1:0]          element_count;
  logic signed [SAMPLE_W-1:0] incoming [NUM_ELEMS];
  logic                      accept;

  assign full   = q_stat.full;
  assign accept = push && !full;
  assign q_wr   = accept && ((opcode == OP_CLEAR) || end_of_sample);

  // Elements that never arrived count as zero.
  always_comb begin
    q_word = '0;
    q_word[NUM_ELEMS*SAMPLE_W] = (opcode == OP_CLEAR);
    for (int j = 0; j < NUM_ELEMS; j++) begin
      if (element_count > CNT_W'(j)) begin
        q_word[j*SAMPLE_W +: SAMPLE_W] = incoming[j];
      end else if (element_count == CNT_W'(j)) begin
        q_word[j*SAMPLE_W +: SAMPLE_W] = element_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (accept && (opcode == OP_PUSH)) begin
      if (end_of_sample) begin
        element_count <= '0;
      end else if (element_count < CNT_W'(NUM_ELEMS)) begin
        element_count <= element_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_ELEMS; j++) begin
      if (accept && (opcode == OP_PUSH) && (element_count == CNT_W'(j))) begin
        incoming[j] <= element_value;
      end
    end
  end

endmodule

FILE: sv/dmfe_cmd_queue.sv
// ----------------------------------------------------------------------------
// dmfe_cmd_queue
// Two-entry queue of commands between the front and the back end.
// ----------------------------------------------------------------------------
module dmfe_cmd_queue import dmfe_pkg::*; #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output qstat_t       stat
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign rd_data    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

FILE: sv/dmfe_back.sv
// ----------------------------------------------------------------------------
// dmfe_back
// Holds the history and sequences linear and monomial features out.
// ----------------------------------------------------------------------------
module dmfe_back import dmfe_pkg::*; #(
  parameter int NUM_ELEMS = 2,
  parameter int DELAY     = 2,
  parameter int STRIDES   = 1,
  parameter int ORDER     = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_empty,
  input  logic [NUM_ELEMS*SAMPLE_W:0] cmd_word,
  output logic                        cmd_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output feat_t                       out_feat
);

  localparam int HIST_ROWS = DELAY * STRIDES;
  localparam int LIN_DIM   = DELAY * NUM_ELEMS;
  localparam int IW        = (LIN_DIM > 1) ? $clog2(LIN_DIM) : 1;
  localparam int CW        = $clog2(ORDER + 1);
  localparam int PW        = SAMPLE_W * ORDER;
  localparam int FRAC      = 12 * ORDER;
  localparam int SHL       = (FRAC <= 24) ? 24 - FRAC : 0;
  localparam int SHR       = (FRAC > 24) ? FRAC - 24 : 0;
  localparam int RSH       = (SHR > 0) ? SHR - 1 : 0;
  localparam int EW        = PW + 25;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LIN  = 5'b00010,
    S_LOAD = 5'b00100,
    S_MUL  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                     state;
  logic signed [SAMPLE_W-1:0] hist [HIST_ROWS][NUM_ELEMS];
  logic signed [SAMPLE_W-1:0] lin_tap [LIN_DIM];
  logic [IW-1:0]              lin_i;
  logic [IW-1:0]              idx [ORDER];
  logic [IW-1:0]              idx_adv [ORDER];
  logic [IW-1:0]              fq [ORDER];
  logic [CW-1:0]              mcnt;
  logic signed [PW-1:0]       prod;
  logic signed [PW+15:0]      mul_full;
  logic [INDEX_W-1:0]         kidx;
  logic                       out_valid;
  logic [IW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] rd_val;
  logic                       slot_free;
  logic                       more;
  logic signed [FEAT_W-1:0]   conv;
  logic signed [FEAT_W-1:0]   lin_q824;
  logic signed [EW-1:0]       ext;
  logic signed [EW-1:0]       scaled;
  logic signed [EW-1:0]       rnd;
  logic [EW-32:0]             hi;
  logic                       out_wr;
  feat_t                      out_next;

  // Linear taps sit at fixed places of the history.
  for (genvar d = 0; d < DELAY; d++) begin : g_row
    for (genvar j = 0; j < NUM_ELEMS; j++) begin : g_el
      assign lin_tap[d*NUM_ELEMS + j] = hist[d*STRIDES][j];
    end
  end

  assign slot_free = !out_valid || out_pop;
  assign out_empty = !out_valid;
  assign cmd_pop   = (state == S_IDLE) && !cmd_empty;

  always_comb begin
    case (state)
      S_LOAD:  rd_addr = idx[0];
      S_MUL:   rd_addr = fq[0];
      default: rd_addr = lin_i;
    endcase
  end
  assign rd_val   = lin_tap[rd_addr];
  assign mul_full = prod * rd_val;
  assign lin_q824 = {{4{rd_val[SAMPLE_W-1]}}, rd_val, 12'b0};

  // Next nondecreasing index tuple.
  always_comb begin
    logic          found;
    logic [IW-1:0] nv;
    int            pos;
    found = 1'b0;
    nv    = '0;
    pos   = 0;
    for (int p = ORDER - 1; p >= 0; p--) begin
      if (!found && (idx[p] != IW'(LIN_DIM - 1))) begin
        found = 1'b1;
        pos   = p;
        nv    = idx[p] + IW'(1);
      end
    end
    for (int q = 0; q < ORDER; q++) begin
      idx_adv[q] = (found && (q >= pos)) ? nv : idx[q];
    end
    more = found;
  end

  // Scale the product to Q8.24, rounding half up when bits are dropped,
  // then saturate to 32 bits.
  always_comb begin
    ext    = EW'(prod);
    rnd    = (SHR > 0) ? (EW'(1) <<< RSH) : '0;
    scaled = ext <<< SHL;
    if (SHR > 0) begin
      scaled = (scaled + rnd) >>> SHR;
    end
    hi = scaled[EW-1:31];
    if ((&hi) || !(|hi)) begin
      conv = scaled[FEAT_W-1:0];
    end else if (scaled[EW-1]) begin
      conv = 32'sh8000_0000;
    end else begin
      conv = 32'sh7fff_ffff;
    end
  end

  always_comb begin
    out_wr   = 1'b0;
    out_next = out_feat;
    if ((state == S_LIN) && slot_free) begin
      out_wr           = 1'b1;
      out_next.value   = lin_q824;
      out_next.index   = kidx;
      out_next.is_mono = 1'b0;
      out_next.last    = 1'b0;
    end else if ((state == S_EMIT) && slot_free) begin
      out_wr           = 1'b1;
      out_next.value   = conv;
      out_next.index   = kidx;
      out_next.is_mono = 1'b1;
      out_next.last    = !more;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int r = 0; r < HIST_ROWS; r++) begin
        for (int j = 0; j < NUM_ELEMS; j++) begin
          hist[r][j] <= '0;
        end
      end
    end else begin
      out_valid <= out_wr || (out_valid && !out_pop);
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd_word[NUM_ELEMS*SAMPLE_W] == OP_CLEAR) begin
              for (int r = 0; r < HIST_ROWS; r++) begin
                for (int j = 0; j < NUM_ELEMS; j++) begin
                  hist[r][j] <= '0;
                end
              end
            end else begin
              for (int r = HIST_ROWS - 1; r > 0; r--) begin
                for (int j = 0; j < NUM_ELEMS; j++) begin
                  hist[r][j] <= hist[r-1][j];
                end
              end
              for (int j = 0; j < NUM_ELEMS; j++) begin
                hist[0][j] <= cmd_word[j*SAMPLE_W +: SAMPLE_W];
              end
              state <= S_LIN;
            end
          end
        end
        S_LIN: begin
          if (slot_free && (lin_i == IW'(LIN_DIM - 1))) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= (ORDER == 1) ? S_EMIT : S_MUL;
        end
        S_MUL: begin
          if (mcnt == CW'(1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= more ? S_LOAD : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: counters, tuple, product and the output word.
  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_feat <= out_next;
      kidx     <= kidx + INDEX_W'(1);
    end
    case (state)
      S_IDLE: begin
        lin_i <= '0;
        kidx  <= '0;
        for (int q = 0; q < ORDER; q++) begin
          idx[q] <= '0;
        end
      end
      S_LIN: begin
        if (slot_free) begin
          lin_i <= lin_i + IW'(1);
        end
      end
      S_LOAD: begin
        prod <= PW'(rd_val);
        mcnt <= CW'(ORDER - 1);
        for (int q = 0; q < ORDER - 1; q++) begin
          fq[q] <= idx[q+1];
        end
        fq[ORDER-1] <= idx[ORDER-1];
      end
      S_MUL: begin
        prod <= mul_full[PW-1:0];
        mcnt <= mcnt - CW'(1);
        for (int q = 0; q < ORDER - 1; q++) begin
          fq[q] <= fq[q+1];
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          for (int q = 0; q < ORDER; q++) begin
            idx[q] <= idx_adv[q];
          end
        end
      end
      default: begin
        lin_i <= lin_i;
      end
    endcase
  end

endmodule

FILE: sv/delay_monomial_feature_expander_unit.sv
// ----------------------------------------------------------------------------
// delay_monomial_feature_expander_unit
// Nonlinear vector autoregression feature expander with a queue interface.
// ----------------------------------------------------------------------------
// Sample vectors arrive one Q4.12 element per input word; a word is taken
// every cycle unless the command queue is full. The word that carries
// end_of_sample completes the sample (missing elements count as zero, extra
// elements are dropped), and the back end shifts it into a history of
// DELAY*STRIDES samples. It then emits DELAY*NUM_ELEMS linear features, one
// per cycle while the output slot is free, followed by every monomial of
// ORDER linear features with nondecreasing indices in lexicographic order.
// Each monomial is built in steps: the first factor is loaded, ORDER-1
// further factors pass through a single shared multiplier, and the result
// is rounded, saturated and written to the output word. At the default
// sizes a completed sample yields 14 output words: 4 linear features and
// 10 monomials. A clear word zeroes the history and emits nothing. The
// two-entry command queue lets the front keep taking words while the back
// end is busy, and the output register lets the back end finish the next
// word while the current one waits to be popped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module delay_monomial_feature_expander_unit import dmfe_pkg::*; #(
  parameter int NUM_ELEMS = 2,
  parameter int DELAY     = 2,
  parameter int STRIDES   = 1,
  parameter int ORDER     = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       opcode,
  input  logic signed [SAMPLE_W-1:0] element_value,
  input  logic                       end_of_sample,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [FEAT_W-1:0]   feature_value,
  output logic [INDEX_W-1:0]         feature_index,
  output logic                       is_monomial,
  output logic                       last_feature
);

  localparam int WORD_W = NUM_ELEMS * SAMPLE_W + 1;

  qstat_t            q_stat;
  logic              q_wr;
  logic [WORD_W-1:0] q_word;
  logic [WORD_W-1:0] cmd_word;
  logic              cmd_pop;
  feat_t             feat;

  // The front assembles samples and turns completed ones and clears into
  // commands.
  dmfe_front #(
    .NUM_ELEMS (NUM_ELEMS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .element_value (element_value),
    .end_of_sample (end_of_sample),
    .q_stat        (q_stat),
    .q_wr          (q_wr),
    .q_word        (q_word)
  );

  // Commands wait here while the back end works through a sample.
  dmfe_cmd_queue #(
    .W (WORD_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_word),
    .rd_en   (cmd_pop),
    .rd_data (cmd_word),
    .stat    (q_stat)
  );

  // The back end owns the history and produces the feature words.
  dmfe_back #(
    .NUM_ELEMS (NUM_ELEMS),
    .DELAY     (DELAY),
    .STRIDES   (STRIDES),
    .ORDER     (ORDER)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_stat.empty),
    .cmd_word  (cmd_word),
    .cmd_pop   (cmd_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_feat  (feat)
  );

  assign feature_value = feat.value;
  assign feature_index = feat.index;
  assign is_monomial   = feat.is_mono;
  assign last_feature  = feat.last;

  // The front never writes a command into a full queue.
  `DMFE_ASSERT(a_no_q_overflow, clk, rst, !(q_wr && q_stat.full))
  // The back end never takes a command from an empty queue.
  `DMFE_ASSERT(a_no_q_underflow, clk, rst, !(cmd_pop && q_stat.empty))
  // The closing word of a feature vector is always a monomial.
  `DMFE_ASSERT(a_last_is_mono, clk, rst, !(!empty && last_feature && !is_monomial))
  // A popped last word leaves the output either empty or on a new vector.
  `DMFE_ASSERT_NEXT(a_new_vector, clk, rst, !empty && pop && last_feature,
                    empty || (feature_index == '0))

endmodule
